[rtl/core/lsth_pkg.sv]
// Shared types and constants for the line segment table hit test core.
// Holds the request/response payload structs, code enums, controller states
// and the command/status structs between the controller and the datapath.
`default_nettype none

package lsth_pkg;

    localparam int FIELD_W   = 16;
    localparam int TOL_W     = 20;
    localparam int IDX_OUT_W = 6;
    localparam int CNT_OUT_W = 7;

    localparam logic [TOL_W-1:0] TOL_RESET = 20'd500;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_DEL   = 2'd1,
        REQ_QUERY = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ROLE_NONE  = 2'd0,
        ROLE_START = 2'd1,
        ROLE_END   = 2'd2
    } t_role;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] end_x;
        logic signed [FIELD_W-1:0] end_y;
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [1:0]           role;
        logic [IDX_OUT_W-1:0] line_index;
        logic [CNT_OUT_W-1:0] line_count;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2,
        S_REPLY = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;      // capture the request
        logic    issue;     // read one entry into the compare pipeline
        logic    flush;     // drop everything in the compare pipeline
        logic    move;      // read one entry and write it one slot lower
        logic    append;    // write the request segment at the end of the table
        logic    drop;      // one segment fewer
        logic    reply;     // load the result register
        t_status status;
        logic    use_idx;
        logic    use_role;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_hit;
        logic pipe_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/core/lsth_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lsth_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/lsth_ctrl.sv]
// Controller for the line segment table: sequences scans, shifts and replies.
// Depends on lsth_pkg.
`default_nettype none

module lsth_ctrl #(
    parameter int MAX_SEGMENTS = 64,
    localparam int AW = $clog2(MAX_SEGMENTS),
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [1:0]         i_req_type,
    output logic                    o_busy,
    output lsth_pkg::t_dp_cmd       o_cmd,
    output logic [AW-1:0]           o_rd_addr,
    input  wire lsth_pkg::t_dp_stat i_stat,
    input  wire logic [AW-1:0]      i_hit_idx,
    input  wire logic [CW-1:0]      i_count
);

    lsth_pkg::t_state  r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [CW-1:0]     r_i, n_i;
    lsth_pkg::t_status r_status, n_status;
    logic              r_use_idx, n_use_idx;
    logic              r_use_role, n_use_role;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsth_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_op       <= n_op;
        r_i        <= n_i;
        r_status   <= n_status;
        r_use_idx  <= n_use_idx;
        r_use_role <= n_use_role;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_i        = r_i;
        n_status   = r_status;
        n_use_idx  = r_use_idx;
        n_use_role = r_use_role;
        o_cmd      = '0;
        o_rd_addr  = r_i[AW-1:0];

        case (r_state)
            lsth_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_req_type;
                    n_i        = '0;
                    n_status   = lsth_pkg::ST_NOMATCH;
                    n_use_idx  = 1'b0;
                    n_use_role = 1'b0;
                    if (i_req_type inside {lsth_pkg::REQ_ADD, lsth_pkg::REQ_DEL,
                                           lsth_pkg::REQ_QUERY}) begin
                        n_state = lsth_pkg::S_SCAN;
                    end else begin
                        n_state = lsth_pkg::S_REPLY;
                    end
                end
            end

            lsth_pkg::S_SCAN: begin
                if (i_stat.out_hit) begin
                    // First hit in table order; later reads in flight are discarded.
                    o_cmd.flush = 1'b1;
                    n_use_idx   = 1'b1;
                    case (r_op)
                        lsth_pkg::REQ_DEL: begin
                            n_status = lsth_pkg::ST_DONE;
                            n_i      = CW'(i_hit_idx) + CW'(1);
                            n_state  = lsth_pkg::S_SHIFT;
                        end
                        lsth_pkg::REQ_ADD: begin
                            n_status = lsth_pkg::ST_DUP;
                            n_state  = lsth_pkg::S_REPLY;
                        end
                        default: begin
                            n_status   = lsth_pkg::ST_DONE;
                            n_use_role = 1'b1;
                            n_state    = lsth_pkg::S_REPLY;
                        end
                    endcase
                end else if (r_i < i_count) begin
                    o_cmd.issue = 1'b1;
                    n_i         = r_i + CW'(1);
                end else if (!i_stat.pipe_busy) begin
                    n_state = lsth_pkg::S_REPLY;
                    if (r_op == lsth_pkg::REQ_ADD) begin
                        if (i_count == CW'(MAX_SEGMENTS)) begin
                            n_status = lsth_pkg::ST_FULL;
                        end else begin
                            o_cmd.append = 1'b1;
                            n_status     = lsth_pkg::ST_DONE;
                            n_use_idx    = 1'b1;
                        end
                    end else begin
                        n_status = lsth_pkg::ST_NOMATCH;
                    end
                end
            end

            lsth_pkg::S_SHIFT: begin
                if (r_i < i_count) begin
                    o_cmd.move = 1'b1;
                    n_i        = r_i + CW'(1);
                end else begin
                    // The last move lands at the same edge as the count update.
                    o_cmd.drop = 1'b1;
                    n_state    = lsth_pkg::S_REPLY;
                end
            end

            lsth_pkg::S_REPLY: begin
                o_cmd.reply    = 1'b1;
                o_cmd.status   = r_status;
                o_cmd.use_idx  = r_use_idx;
                o_cmd.use_role = r_use_role;
                n_state        = lsth_pkg::S_IDLE;
            end

            default: begin
                n_state = lsth_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != lsth_pkg::S_IDLE);

endmodule

`default_nettype wire

[rtl/core/lsth_dp.sv]
// Datapath for the line segment table: segment RAM, count, tolerance register,
// a four-stage compare pipeline and the result register. Depends on lsth_pkg, lsth_ram.
`default_nettype none

module lsth_dp #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 16,
    localparam int AW = $clog2(MAX_SEGMENTS),
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire lsth_pkg::t_req                 i_req,
    input  wire lsth_pkg::t_dp_cmd              i_cmd,
    input  wire logic [AW-1:0]                  i_rd_addr,
    output lsth_pkg::t_dp_stat                  o_stat,
    output logic [AW-1:0]                       o_hit_idx,
    output logic [CW-1:0]                       o_count,
    input  wire logic                           i_cfg_valid,
    input  wire logic [lsth_pkg::TOL_W-1:0]     i_cfg_data,
    output logic                                o_done,
    output lsth_pkg::t_rsp                      o_rsp
);

    localparam int CB   = COORD_BITS;
    localparam int EW   = 4 * CB;
    localparam int PW   = 2 * CB + 2;
    localparam int XW   = 2 * CB + 3;
    localparam int CMPW = (XW > lsth_pkg::TOL_W + 1) ? XW : lsth_pkg::TOL_W + 1;

    lsth_pkg::t_req            r_req;
    logic [CW-1:0]             r_count;
    logic [lsth_pkg::TOL_W-1:0] r_tol;

    // Table RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] rd_data;
    logic [EW-1:0] req_entry;
    logic          r_mv;
    logic [AW-1:0] r_mv_dst;

    lsth_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_data)
    );

    assign req_entry = {r_req.end_y[CB-1:0], r_req.end_x[CB-1:0],
                        r_req.start_y[CB-1:0], r_req.start_x[CB-1:0]};

    always_comb begin
        ram_we    = i_cmd.append | r_mv;
        ram_waddr = r_mv ? r_mv_dst : r_count[AW-1:0];
        ram_wdata = r_mv ? rd_data : req_entry;
    end

    // Stage 1 inputs: decode the entry just read.
    logic signed [CB-1:0] e_sx, e_sy, e_ex, e_ey, q_px, q_py;
    logic signed [CB:0]   d_xp, d_yl, d_yp, d_xl;

    assign e_sx = rd_data[CB-1:0];
    assign e_sy = rd_data[2*CB-1:CB];
    assign e_ex = rd_data[3*CB-1:2*CB];
    assign e_ey = rd_data[4*CB-1:3*CB];
    assign q_px = r_req.point_x[CB-1:0];
    assign q_py = r_req.point_y[CB-1:0];

    assign d_xp = (CB+1)'(q_px) - (CB+1)'(e_sx);
    assign d_yl = (CB+1)'(e_ey) - (CB+1)'(e_sy);
    assign d_yp = (CB+1)'(q_py) - (CB+1)'(e_sy);
    assign d_xl = (CB+1)'(e_ex) - (CB+1)'(e_sx);

    logic r_v0, r_v1, r_v2, r_v3;
    logic [AW-1:0] r_idx0, r_idx1, r_idx2, r_idx3;
    logic signed [CB:0] r_dxp, r_dyl, r_dyp, r_dxl;
    logic r_eq_dup, r_eq_end, r_eq_start;
    logic signed [PW-1:0] r_p1, r_p2;
    logic r_hit2, r_hit3;
    lsth_pkg::t_role r_role2, r_role3;

    // Stage 3 inputs: cross product against the tolerance window.
    logic signed [XW-1:0]   cross_val;
    logic signed [CMPW-1:0] cross_ext, tol_pos, tol_neg;
    logic                   mag_ok;
    logic                   eq_hit;
    lsth_pkg::t_role        eq_role;

    assign cross_val = XW'(r_p1) - XW'(r_p2);
    assign cross_ext = CMPW'(cross_val);
    assign tol_pos   = CMPW'(r_tol);
    assign tol_neg   = -tol_pos;
    assign mag_ok    = (cross_ext <= tol_pos) && (cross_ext >= tol_neg);

    always_comb begin
        case (r_req.req_type)
            lsth_pkg::REQ_ADD:   eq_hit = r_eq_dup;
            lsth_pkg::REQ_QUERY: eq_hit = r_eq_end | r_eq_start;
            default:             eq_hit = 1'b0;
        endcase
        if (r_eq_end) begin
            eq_role = lsth_pkg::ROLE_END;
        end else if (r_eq_start) begin
            eq_role = lsth_pkg::ROLE_START;
        end else begin
            eq_role = lsth_pkg::ROLE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_mv <= 1'b0;
        end else if (i_cmd.flush) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_mv <= i_cmd.move;
        end else begin
            r_v0 <= i_cmd.issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_mv <= i_cmd.move;
        end

        r_mv_dst <= i_rd_addr - AW'(1);

        r_idx0     <= i_rd_addr;
        r_idx1     <= r_idx0;
        r_dxp      <= d_xp;
        r_dyl      <= d_yl;
        r_dyp      <= d_yp;
        r_dxl      <= d_xl;
        r_eq_dup   <= (rd_data == req_entry);
        r_eq_end   <= (e_ex == q_px) && (e_ey == q_py);
        r_eq_start <= (e_sx == q_px) && (e_sy == q_py);

        r_idx2  <= r_idx1;
        r_p1    <= r_dxp * r_dyl;
        r_p2    <= r_dyp * r_dxl;
        r_hit2  <= eq_hit;
        r_role2 <= eq_role;

        r_idx3  <= r_idx2;
        r_hit3  <= (r_req.req_type == lsth_pkg::REQ_DEL) ? mag_ok : r_hit2;
        r_role3 <= r_role2;
    end

    assign o_stat.out_hit   = r_v3 & r_hit3;
    assign o_stat.pipe_busy = r_v0 | r_v1 | r_v2 | r_v3;
    assign o_hit_idx        = r_idx3;
    assign o_count          = r_count;

    // Request, count, tolerance and result.
    logic [AW-1:0]   r_res_idx;
    lsth_pkg::t_role r_res_role;
    logic            r_done;
    lsth_pkg::t_rsp  r_rsp;
    logic [AW+lsth_pkg::IDX_OUT_W-1:0] idx_ext;
    logic [CW+lsth_pkg::CNT_OUT_W-1:0] cnt_ext;

    assign idx_ext = {{lsth_pkg::IDX_OUT_W{1'b0}}, r_res_idx};
    assign cnt_ext = {{lsth_pkg::CNT_OUT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tol   <= lsth_pkg::TOL_RESET;
            r_done  <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.drop) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            r_done <= i_cmd.reply;
        end

        if (i_cmd.load) begin
            r_req <= i_req;
        end

        if (o_stat.out_hit) begin
            r_res_idx  <= r_idx3;
            r_res_role <= r_role3;
        end else if (i_cmd.append) begin
            r_res_idx <= r_count[AW-1:0];
        end

        if (i_cmd.reply) begin
            r_rsp.status     <= i_cmd.status;
            r_rsp.role       <= i_cmd.use_role ? r_res_role : lsth_pkg::ROLE_NONE;
            r_rsp.line_index <= i_cmd.use_idx ? idx_ext[lsth_pkg::IDX_OUT_W-1:0] : '0;
            r_rsp.line_count <= cnt_ext[lsth_pkg::CNT_OUT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

[rtl/core/line_segment_table_hit_test_core.sv]
// Line segment table hit test core. A request scans the n held segments one per cycle
// through the RAM read port and a four-stage compare pipeline until the first match or
// the end of the table (an undefined request skips the scan), and a delete of entry h
// then moves each later entry down one slot. One request at a time; busy drops in the
// strobe cycle, which cannot be stalled. Synchronous reset empties the table and sets
// the tolerance to 500.
`default_nettype none

module line_segment_table_hit_test_core #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire lsth_pkg::t_req             i_req,
    output logic                            o_done,
    output lsth_pkg::t_rsp                  o_rsp,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [lsth_pkg::TOL_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    lsth_pkg::t_dp_cmd  cmd;
    lsth_pkg::t_dp_stat stat;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      hit_idx;
    logic [CW-1:0]      count;

    // The tolerance register takes a transfer in any cycle.
    assign o_cfg_ready = 1'b1;

    lsth_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req.req_type),
        .o_busy     (o_busy),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .i_stat     (stat),
        .i_hit_idx  (hit_idx),
        .i_count    (count)
    );

    lsth_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .i_rd_addr   (rd_addr),
        .o_stat      (stat),
        .o_hit_idx   (hit_idx),
        .o_count     (count),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

[tb/line_segment_table_hit_test_core_tb.sv]
// Self-checking testbench for line_segment_table_hit_test_core: directed and random
// add, delete, endpoint-query and undefined requests across several hit tolerances,
// checked against an in-bench model of the segment table. Depends on lsth_pkg and the core.
module line_segment_table_hit_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsth_pkg::*;

    localparam int MAX_SEG     = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 200;
    localparam logic [1:0] REQ_UNDEF = 2'd3;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_start = 1'b0;
    logic             o_busy;
    t_req             i_req = '0;
    logic             o_done;
    t_rsp             o_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [TOL_W-1:0] i_cfg_data = '0;

    // Model of the segment table: entries pack sx, sy, ex, ey from the low slot up.
    logic [63:0]      seg_table [MAX_SEG];
    int               seg_count = 0;
    logic [TOL_W-1:0] hit_tol = TOL_RESET;

    t_req             req_backlog [$];
    t_rsp             pending_rsp [$];
    logic [63:0]      seg_pool [$];
    t_rsp             expd;
    bit               req_taken = 1'b0;
    int               sent_count = 0;
    int               fail_count = 0;
    int               stall_cycles;

    line_segment_table_hit_test_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint coord(input logic [63:0] seg, input int k);
        return longint'($signed(seg[16*k +: 16]));
    endfunction

    function automatic t_rsp resolve_request(input t_req r);
        t_rsp        rsp;
        logic [63:0] seg;
        int          n;
        bit          hit;
        longint      px, py, sx, sy, ex, ey, xprod;
        rsp = '0;
        rsp.status = ST_NOMATCH;
        rsp.role = ROLE_NONE;
        n = seg_count;
        hit = 1'b0;
        px = longint'($signed(r.point_x));
        py = longint'($signed(r.point_y));
        case (r.req_type)
            REQ_ADD: begin
                seg = {r.end_y, r.end_x, r.start_y, r.start_x};
                for (int i = 0; i < n && !hit; i++) begin
                    if (seg_table[i] == seg) begin
                        hit = 1'b1;
                        rsp.status = ST_DUP;
                        rsp.line_index = 6'(i);
                    end
                end
                if (!hit) begin
                    if (n >= MAX_SEG) begin
                        rsp.status = ST_FULL;
                    end else begin
                        seg_table[n] = seg;
                        rsp.line_index = 6'(n);
                        rsp.status = ST_DONE;
                        n++;
                    end
                end
            end
            REQ_DEL: begin
                for (int i = 0; i < n && !hit; i++) begin
                    sx = coord(seg_table[i], 0);
                    sy = coord(seg_table[i], 1);
                    ex = coord(seg_table[i], 2);
                    ey = coord(seg_table[i], 3);
                    xprod = (px - sx) * (ey - sy) - (py - sy) * (ex - sx);
                    if (xprod < 0) xprod = -xprod;
                    if (xprod <= longint'(hit_tol)) begin
                        hit = 1'b1;
                        // Later entries move down one slot to close the gap.
                        for (int j = i; j < n - 1; j++) seg_table[j] = seg_table[j + 1];
                        n--;
                        rsp.line_index = 6'(i);
                        rsp.status = ST_DONE;
                    end
                end
            end
            REQ_QUERY: begin
                // The end point of an entry takes precedence over its start point.
                for (int i = 0; i < n && !hit; i++) begin
                    if (coord(seg_table[i], 2) == px && coord(seg_table[i], 3) == py) begin
                        hit = 1'b1;
                        rsp.role = ROLE_END;
                    end else if (coord(seg_table[i], 0) == px &&
                                 coord(seg_table[i], 1) == py) begin
                        hit = 1'b1;
                        rsp.role = ROLE_START;
                    end
                    if (hit) begin
                        rsp.line_index = 6'(i);
                        rsp.status = ST_DONE;
                    end
                end
            end
            default: ;
        endcase
        seg_count = n;
        rsp.line_count = 7'(n);
        return rsp;
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
            3, 4, 5: return 16'($urandom_range(0, 40)) - 16'd20;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req mk(input logic [1:0] kind, input int sx, input int sy,
                                input int ex, input int ey, input int px, input int py);
        t_req r;
        r.req_type = kind;
        r.start_x = 16'(sx);
        r.start_y = 16'(sy);
        r.end_x = 16'(ex);
        r.end_y = 16'(ey);
        r.point_x = 16'(px);
        r.point_y = 16'(py);
        return r;
    endfunction

    function automatic t_req random_request(input int add_pct, input int del_pct,
                                            input int qry_pct);
        t_req        r;
        int          roll;
        logic [63:0] e;
        longint      sx, sy, ex, ey, px, py;
        r.start_x = pick_coord();
        r.start_y = pick_coord();
        r.end_x = pick_coord();
        r.end_y = pick_coord();
        r.point_x = pick_coord();
        r.point_y = pick_coord();
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
            r.req_type = REQ_ADD;
            if (seg_pool.size() != 0 && $urandom_range(0, 99) < 15) begin
                // Re-adding a known segment: a duplicate or a return after deletion.
                e = seg_pool[$urandom_range(0, seg_pool.size() - 1)];
                {r.end_y, r.end_x, r.start_y, r.start_x} = e;
            end else begin
                if ($urandom_range(0, 19) == 0) begin
                    r.end_x = r.start_x;
                    r.end_y = r.start_y;
                end
                seg_pool.push_back({r.end_y, r.end_x, r.start_y, r.start_x});
                if (seg_pool.size() > 96) void'(seg_pool.pop_front());
            end
        end else if (roll < add_pct + del_pct + qry_pct) begin
            r.req_type = (roll < add_pct + del_pct) ? REQ_DEL : REQ_QUERY;
            if (seg_pool.size() != 0) begin
                e = seg_pool[$urandom_range(0, seg_pool.size() - 1)];
                sx = coord(e, 0);
                sy = coord(e, 1);
                ex = coord(e, 2);
                ey = coord(e, 3);
                px = longint'($signed(r.point_x));
                py = longint'($signed(r.point_y));
                case ($urandom_range(0, 5))
                    0, 1: begin px = sx; py = sy; end
                    2:    begin px = ex; py = ey; end
                    3:    begin px = (sx + ex) / 2; py = (sy + ey) / 2; end
                    4:    begin
                        px = ex + $urandom_range(0, 6) - 3;
                        py = ey + $urandom_range(0, 6) - 3;
                    end
                    default: ;
                endcase
                r.point_x = 16'(px);
                r.point_y = 16'(py);
            end
        end else begin
            r.req_type = REQ_UNDEF;
        end
        return r;
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || i_start || pending_rsp.size() != 0 || o_busy);
    endtask

    // Called at a falling edge with the core idle.
    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        repeat ($urandom_range(0, 3)) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        hit_tol = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 20'($urandom);
    endtask

    // Request driver: holds start with its request until the transfer, then
    // picks the next one or leaves start low.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_start || req_taken)) begin
            if (req_backlog.size() != 0 &&
                ((sent_count >= 420 && sent_count < 580) || $urandom_range(0, 99) >= 23)) begin
                i_req <= req_backlog.pop_front();
                i_start <= 1'b1;
                sent_count++;
            end else begin
                i_start <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // Result monitor; the result is popped before a new request's
    // expectation is pushed in the same cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_rsp.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    fail_count++;
                end else begin
                    expd = pending_rsp.pop_front();
                    if (o_rsp.status !== expd.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               expd.status, o_rsp.status);
                        fail_count++;
                    end
                    if (o_rsp.role !== expd.role) begin
                        $error("role mismatch: expected %0d, actual %0d",
                               expd.role, o_rsp.role);
                        fail_count++;
                    end
                    if (o_rsp.line_index !== expd.line_index) begin
                        $error("line_index mismatch: expected %0d, actual %0d",
                               expd.line_index, o_rsp.line_index);
                        fail_count++;
                    end
                    if (o_rsp.line_count !== expd.line_count) begin
                        $error("line_count mismatch: expected %0d, actual %0d",
                               expd.line_count, o_rsp.line_count);
                        fail_count++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                pending_rsp.push_back(resolve_request(i_req));
                req_taken = 1'b1;
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("[line_segment_table_hit_test_core] ERROR");
        $finish;
    end

    initial begin
        logic [TOL_W-1:0] tol_steps [5];
        tol_steps[0] = '0;
        tol_steps[1] = '1;
        tol_steps[2] = 20'($urandom);
        tol_steps[3] = TOL_RESET;
        tol_steps[4] = 20'($urandom_range(1, 5000));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset tolerance.
        req_backlog.push_back(mk(REQ_QUERY, 0, 0, 0, 0, 0, 0));
        req_backlog.push_back(mk(REQ_DEL, 0, 0, 0, 0, 0, 0));
        req_backlog.push_back(mk(REQ_UNDEF, 1, 2, 3, 4, 5, 6));
        req_backlog.push_back(mk(REQ_ADD, -32768, -32768, 32767, 32767, 0, 0));
        req_backlog.push_back(mk(REQ_ADD, 32767, -32768, -32768, 32767, 0, 0));
        req_backlog.push_back(mk(REQ_ADD, -32768, -32768, 32767, 32767, 9, 9));
        req_backlog.push_back(mk(REQ_ADD, 32767, 32767, 100, -100, 0, 0));
        req_backlog.push_back(mk(REQ_QUERY, 0, 0, 0, 0, 32767, 32767));
        req_backlog.push_back(mk(REQ_QUERY, 0, 0, 0, 0, 32767, -32768));
        req_backlog.push_back(mk(REQ_QUERY, 0, 0, 0, 0, -32768, 32767));
        req_backlog.push_back(mk(REQ_QUERY, 0, 0, 0, 0, 100, -100));
        req_backlog.push_back(mk(REQ_QUERY, 0, 0, 0, 0, 1, 2));
        req_backlog.push_back(mk(REQ_DEL, 0, 0, 0, 0, 0, 0));
        req_backlog.push_back(mk(REQ_ADD, 5, 5, 5, 5, 0, 0));
        req_backlog.push_back(mk(REQ_DEL, 0, 0, 0, 0, 1000, -1000));
        req_backlog.push_back(mk(REQ_UNDEF, -1, -1, -1, -1, -1, -1));
        req_backlog.push_back(mk(REQ_ADD, -1, -1, -1, -1, -1, -1));
        req_backlog.push_back(mk(REQ_ADD, 0, 0, 0, 0, 0, 0));
        req_backlog.push_back(mk(REQ_QUERY, -1, -1, -1, -1, 0, 0));
        req_backlog.push_back(mk(REQ_DEL, 0, 0, 0, 0, -1, -1));
        req_backlog.push_back(mk(REQ_QUERY, 0, 0, 0, 0, -1, -1));
        req_backlog.push_back(mk(REQ_DEL, 0, 0, 0, 0, 40000, -40000));
        wait_idle();

        // Each phase fills the table past full, then mostly drains it.
        foreach (tol_steps[p]) begin
            write_tolerance(tol_steps[p]);
            repeat (110) req_backlog.push_back(random_request(85, 5, 8));
            repeat (60) req_backlog.push_back(random_request(12, 60, 25));
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("[line_segment_table_hit_test_core] OK");
        else
            $display("[line_segment_table_hit_test_core] ERROR");
        $finish;
    end
endmodule
